/* rtl/core/dsched_pkg.sv */
package dsched_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int BLOCK_BITS  = 24;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TAG_W       = 8;
  localparam int STAT_W      = 3;
  localparam int TRAVEL_W    = 32;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = BLOCK_BITS + 1;

  localparam logic OP_ENQUEUE  = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SCHED_MODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DISK_BLOCKS = CFG_IDX_W'(1);

  localparam logic [MODE_W-1:0] MODE_FCFS  = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_CSCAN = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_SSTF  = MODE_W'(2);

  typedef enum logic [STAT_W-1:0] {
    ST_ENQUEUED   = 3'd0,
    ST_DISPATCHED = 3'd1,
    ST_FULL       = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_RANGE      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_EXEC,
    CMD_SCAN,
    CMD_PICK,
    CMD_SHIFT,
    CMD_RESULT
  } dp_cmd_t;

  typedef struct packed {
    logic dispatch;
    logic empty;
    logic scan_last;
    logic shift_last;
  } dp_stat_t;

  typedef struct packed {
    logic [BLOCK_BITS-1:0] blk;
    logic [TAG_W-1:0]      tag;
  } entry_t;

  function automatic logic [BLOCK_BITS-1:0] abs_diff(input logic [BLOCK_BITS-1:0] a,
                                                     input logic [BLOCK_BITS-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

/* rtl/core/dsched_ctrl.sv */
module dsched_ctrl
  import dsched_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output logic     in_stall,
  output logic     out_valid,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_PICK,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = CMD_IDLE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd = CMD_EXEC;
        if (stat.dispatch && !stat.empty) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd = CMD_SCAN;
        if (stat.scan_last) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        cmd        = CMD_PICK;
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        cmd = CMD_SHIFT;
        if (stat.shift_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd        = CMD_RESULT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd == CMD_RESULT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/dsched_dp.sv */
module dsched_dp
  import dsched_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic                  opcode,
  input  logic [BLOCK_BITS-1:0] req_block,
  input  logic [TAG_W-1:0]      req_tag,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [STAT_W-1:0]     status,
  output logic [TAG_W-1:0]      out_tag,
  output logic [BLOCK_BITS-1:0] out_block,
  output logic [BLOCK_BITS-1:0] seek_distance,
  output logic [TRAVEL_W-1:0]   total_travel,
  output logic [CNT_W-1:0]      pending_count
);

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  logic                  op_q;
  logic [BLOCK_BITS-1:0] blk_q;
  logic [TAG_W-1:0]      tag_q;

  logic [MODE_W-1:0]     mode;
  logic [CFG_DATA_W-1:0] dblocks;
  logic [CNT_W-1:0]      count;
  logic [BLOCK_BITS-1:0] head;
  logic [TRAVEL_W-1:0]   travel;

  logic [IDX_W-1:0]      eval_idx;
  logic [IDX_W-1:0]      best_idx, low_idx;
  entry_t                best_ent, low_ent;
  logic [BLOCK_BITS-1:0] bestd;
  logic                  found;

  logic [IDX_W-1:0]      wptr;
  status_t               res_status;
  entry_t                sel_ent;
  logic [BLOCK_BITS-1:0] res_seek;

  logic                  is_oor, is_full;
  logic [BLOCK_BITS-1:0] scan_d;
  logic                  scan_ge;
  logic                  use_low;
  logic [IDX_W-1:0]      pick_idx;
  entry_t                pick_ent;
  logic [TRAVEL_W:0]     tsum;
  logic [TRAVEL_W-1:0]   travel_next;

  assign cfg_ready = 1'b1;

  assign is_oor  = {1'b0, blk_q} >= dblocks;
  assign is_full = count >= CNT_W'(QUEUE_DEPTH);

  assign stat.dispatch   = (op_q == OP_DISPATCH);
  assign stat.empty      = (count == '0);
  assign stat.scan_last  = (CNT_W'(eval_idx) + CNT_W'(1)) == count;
  assign stat.shift_last = (CNT_W'(wptr) + CNT_W'(1)) >= count;

  assign scan_d  = abs_diff(rd_data.blk, head);
  assign scan_ge = rd_data.blk >= head;

  assign use_low  = (mode == MODE_CSCAN) && !found;
  assign pick_idx = use_low ? low_idx : best_idx;
  assign pick_ent = use_low ? low_ent : best_ent;

  assign tsum        = {1'b0, travel} + (TRAVEL_W + 1)'(res_seek);
  assign travel_next = tsum[TRAVEL_W] ? '1 : tsum[TRAVEL_W-1:0];

  always_comb begin
    rd_addr   = '0;
    mem_we    = 1'b0;
    mem_waddr = wptr;
    mem_wdata = rd_data;
    case (cmd)
      CMD_EXEC: begin
        mem_we    = (op_q == OP_ENQUEUE) && !is_oor && !is_full;
        mem_waddr = count[IDX_W-1:0];
        mem_wdata = '{blk: blk_q, tag: tag_q};
      end
      CMD_SCAN:  rd_addr = eval_idx + IDX_W'(1);
      CMD_PICK:  rd_addr = pick_idx + IDX_W'(1);
      CMD_SHIFT: begin
        rd_addr = wptr + IDX_W'(2);
        mem_we  = !stat.shift_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_CSCAN;
      dblocks <= CFG_DATA_W'(1) << BLOCK_BITS;
      count   <= '0;
      head    <= '0;
      travel  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SCHED_MODE) begin
          mode <= cfg_data[MODE_W-1:0];
        end else if (cfg_index == CFG_DISK_BLOCKS) begin
          dblocks <= cfg_data;
        end
      end
      case (cmd)
        CMD_LOAD: begin
          op_q  <= opcode;
          blk_q <= req_block;
          tag_q <= req_tag;
        end
        CMD_EXEC: begin
          sel_ent  <= '0;
          res_seek <= '0;
          eval_idx <= '0;
          if (op_q == OP_ENQUEUE) begin
            if (is_oor) begin
              res_status <= ST_RANGE;
            end else if (is_full) begin
              res_status <= ST_FULL;
            end else begin
              res_status <= ST_ENQUEUED;
              count      <= count + CNT_W'(1);
            end
          end else if (count == '0) begin
            res_status <= ST_EMPTY;
          end else begin
            res_status <= ST_DISPATCHED;
          end
        end
        CMD_SCAN: begin
          eval_idx <= eval_idx + IDX_W'(1);
          if (eval_idx == '0) begin
            best_idx <= eval_idx;
            best_ent <= rd_data;
            bestd    <= scan_d;
            found    <= scan_ge;
            low_idx  <= eval_idx;
            low_ent  <= rd_data;
          end else begin
            if (rd_data.blk < low_ent.blk) begin
              low_idx <= eval_idx;
              low_ent <= rd_data;
            end
            if (mode == MODE_CSCAN) begin
              if (scan_ge && (!found || rd_data.blk < best_ent.blk)) begin
                best_idx <= eval_idx;
                best_ent <= rd_data;
                found    <= 1'b1;
              end
            end else if (mode == MODE_SSTF) begin
              if (scan_d < bestd) begin
                best_idx <= eval_idx;
                best_ent <= rd_data;
                bestd    <= scan_d;
              end
            end
          end
        end
        CMD_PICK: begin
          sel_ent  <= pick_ent;
          res_seek <= abs_diff(pick_ent.blk, head);
          head     <= pick_ent.blk;
          wptr     <= pick_idx;
        end
        CMD_SHIFT: begin
          if (stat.shift_last) begin
            count <= count - CNT_W'(1);
          end else begin
            wptr <= wptr + IDX_W'(1);
          end
        end
        CMD_RESULT: begin
          travel        <= travel_next;
          status        <= res_status;
          out_tag       <= sel_ent.tag;
          out_block     <= sel_ent.blk;
          seek_distance <= res_seek;
          total_travel  <= travel_next;
          pending_count <= count;
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/disk_request_scheduler.sv */
// Disk request scheduler: a table of pending requests with a head position.
// Input channel (in_valid / in_stall): opcode selects enqueue or dispatch;
// enqueue carries req_block and req_tag. Output channel (out_valid /
// out_stall): exactly one result word per input word, in order.
// Configuration channel (cfg_valid / cfg_ready, always ready): index 0 sets
// sched_mode (0 FCFS, 1 C-SCAN, 2 SSTF), index 1 sets disk_blocks.
// One word is worked at a time. A dispatch on a non-empty table scans the
// pending entries to select one, then closes the gap that the taken entry
// leaves; the table memory has one read port, so the selection scan reads
// one entry per cycle and closing the gap moves one entry per cycle.
// The result sits in an output register; the next word is accepted while it
// waits, but a finished result holds in the pipeline until the register is
// free, and in_stall stays high meanwhile.
// Reset empties the table, puts the head at block 0, clears the total, and
// sets C-SCAN mode with the full 2^24 block range.
module disk_request_scheduler
  import dsched_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  opcode,
  input  logic [BLOCK_BITS-1:0] req_block,
  input  logic [TAG_W-1:0]      req_tag,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STAT_W-1:0]     status,
  output logic [TAG_W-1:0]      out_tag,
  output logic [BLOCK_BITS-1:0] out_block,
  output logic [BLOCK_BITS-1:0] seek_distance,
  output logic [TRAVEL_W-1:0]   total_travel,
  output logic [CNT_W-1:0]      pending_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dsched_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  dsched_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .opcode        (opcode),
    .req_block     (req_block),
    .req_tag       (req_tag),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .status        (status),
    .out_tag       (out_tag),
    .out_block     (out_block),
    .seek_distance (seek_distance),
    .total_travel  (total_travel),
    .pending_count (pending_count)
  );

endmodule

/* rtl/core/dsched_chk.sv */
module dsched_chk
  import dsched_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [STAT_W-1:0]     status,
  input logic [TAG_W-1:0]      out_tag,
  input logic [BLOCK_BITS-1:0] out_block,
  input logic [BLOCK_BITS-1:0] seek_distance,
  input logic [TRAVEL_W-1:0]   total_travel,
  input logic [CNT_W-1:0]      pending_count
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_block)
      && $stable(total_travel))
    else $error("stalled result word changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while one is in work");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DISPATCHED |->
      out_tag == '0 && out_block == '0 && seek_distance == '0)
    else $error("non-dispatch result carries request fields");

  a_ranges: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= STAT_W'(ST_RANGE) && pending_count <= CNT_W'(QUEUE_DEPTH))
    else $error("result status or count out of range");

  a_dispatch_seek: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DISPATCHED |-> total_travel >= TRAVEL_W'(seek_distance))
    else $error("total travel below the last seek");

endmodule

bind disk_request_scheduler dsched_chk u_dsched_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .out_tag       (out_tag),
  .out_block     (out_block),
  .seek_distance (seek_distance),
  .total_travel  (total_travel),
  .pending_count (pending_count)
);

/* sim/dsched_checker.sv */
`timescale 1ns / 100ps

module dsched_checker
  import dsched_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  opcode,
  input  logic [BLOCK_BITS-1:0] req_block,
  input  logic [TAG_W-1:0]      req_tag,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [STAT_W-1:0]     status,
  input  logic [TAG_W-1:0]      out_tag,
  input  logic [BLOCK_BITS-1:0] out_block,
  input  logic [BLOCK_BITS-1:0] seek_distance,
  input  logic [TRAVEL_W-1:0]   total_travel,
  input  logic [CNT_W-1:0]      pending_count,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    outstanding
);

  typedef struct packed {
    status_t               st;
    logic [TAG_W-1:0]      tag;
    logic [BLOCK_BITS-1:0] blk;
    logic [BLOCK_BITS-1:0] seek;
    logic [TRAVEL_W-1:0]   travel;
    logic [CNT_W-1:0]      count;
  } sched_result_t;

  logic [BLOCK_BITS-1:0] slot_block [QUEUE_DEPTH];
  logic [TAG_W-1:0]      slot_tag   [QUEUE_DEPTH];
  int                    slot_count;
  logic [BLOCK_BITS-1:0] head_pos;
  logic [TRAVEL_W-1:0]   travel;
  logic [MODE_W-1:0]     cur_mode;
  logic [CFG_DATA_W-1:0] cur_limit;

  sched_result_t result_q [$];
  sched_result_t want;

  function automatic logic [BLOCK_BITS-1:0] head_gap(input logic [BLOCK_BITS-1:0] b);
    return (b >= head_pos) ? b - head_pos : head_pos - b;
  endfunction

  function automatic sched_result_t serve_word(input logic op,
                                               input logic [BLOCK_BITS-1:0] blk,
                                               input logic [TAG_W-1:0] tg);
    sched_result_t r;
    int i;
    int sel;
    int low;
    logic found;
    logic [TRAVEL_W:0] sum;
    r = '0;
    if (op == OP_ENQUEUE) begin
      if ({1'b0, blk} >= cur_limit) begin
        r.st = ST_RANGE;
      end else if (slot_count >= QUEUE_DEPTH) begin
        r.st = ST_FULL;
      end else begin
        slot_block[IDX_W'(slot_count)] = blk;
        slot_tag[IDX_W'(slot_count)] = tg;
        slot_count++;
        r.st = ST_ENQUEUED;
      end
    end else if (slot_count == 0) begin
      r.st = ST_EMPTY;
    end else begin
      sel = 0;
      if (cur_mode == MODE_CSCAN) begin
        found = 1'b0;
        low = 0;
        for (i = 0; i < slot_count; i++) begin
          if (slot_block[IDX_W'(i)] < slot_block[IDX_W'(low)]) low = i;
          if (slot_block[IDX_W'(i)] >= head_pos &&
              (!found || slot_block[IDX_W'(i)] < slot_block[IDX_W'(sel)])) begin
            sel = i;
            found = 1'b1;
          end
        end
        if (!found) sel = low;
      end else if (cur_mode == MODE_SSTF) begin
        for (i = 1; i < slot_count; i++)
          if (head_gap(slot_block[IDX_W'(i)]) < head_gap(slot_block[IDX_W'(sel)])) sel = i;
      end
      r.st = ST_DISPATCHED;
      r.blk = slot_block[IDX_W'(sel)];
      r.tag = slot_tag[IDX_W'(sel)];
      r.seek = head_gap(slot_block[IDX_W'(sel)]);
      head_pos = slot_block[IDX_W'(sel)];
      sum = {1'b0, travel} + (TRAVEL_W + 1)'(r.seek);
      travel = sum[TRAVEL_W] ? '1 : sum[TRAVEL_W-1:0];
      for (i = sel; i + 1 < slot_count; i++) begin
        slot_block[IDX_W'(i)] = slot_block[IDX_W'(i+1)];
        slot_tag[IDX_W'(i)] = slot_tag[IDX_W'(i+1)];
      end
      slot_count--;
    end
    r.travel = travel;
    r.count = CNT_W'(slot_count);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      fail_count++;
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_q.delete();
      slot_count = 0;
      head_pos = '0;
      travel = '0;
      cur_mode = MODE_CSCAN;
      cur_limit = CFG_DATA_W'(1 << BLOCK_BITS);
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          fail_count++;
          $error("result word with nothing pending");
        end else begin
          want = result_q.pop_front();
          check_field("status", 32'(want.st), 32'(status));
          check_field("out_tag", 32'(want.tag), 32'(out_tag));
          check_field("out_block", 32'(want.blk), 32'(out_block));
          check_field("seek_distance", 32'(want.seek), 32'(seek_distance));
          check_field("total_travel", want.travel, total_travel);
          check_field("pending_count", 32'(want.count), 32'(pending_count));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SCHED_MODE:  cur_mode = cfg_data[MODE_W-1:0];
          CFG_DISK_BLOCKS: cur_limit = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) result_q.push_back(serve_word(opcode, req_block, req_tag));
    end
    outstanding = result_q.size();
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import dsched_pkg::*;

  localparam logic [MODE_W-1:0]     MODE_SPARE = MODE_W'(3);
  localparam logic [CFG_DATA_W-1:0] FULL_SPAN  = CFG_DATA_W'(1 << BLOCK_BITS);
  localparam logic [BLOCK_BITS-1:0] TOP_BLOCK  = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  opcode = OP_ENQUEUE;
  logic [BLOCK_BITS-1:0] req_block = '0;
  logic [TAG_W-1:0]      req_tag = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STAT_W-1:0]     status;
  logic [TAG_W-1:0]      out_tag;
  logic [BLOCK_BITS-1:0] out_block;
  logic [BLOCK_BITS-1:0] seek_distance;
  logic [TRAVEL_W-1:0]   total_travel;
  logic [CNT_W-1:0]      pending_count;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    outstanding;

  int   send_idle_pct = 7;
  int   recv_idle_pct = 87;
  logic hold_trigger = 1'b0;
  int   hold_left = 0;

  always #5 clk = ~clk;

  disk_request_scheduler u_dut (.*);
  dsched_checker u_checker (.*);

  // long receiver hold-off, started on request
  always @(negedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_trigger) hold_left <= 400;
  end

  always @(negedge clk)
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);

  task automatic send_word(input logic op, input logic [BLOCK_BITS-1:0] blk,
                           input logic [TAG_W-1:0] tg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    req_block <= blk;
    req_tag <= tg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_policy(input logic [MODE_W-1:0] mode, input logic [CFG_DATA_W-1:0] limit);
    drain();
    write_reg(CFG_SCHED_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_DISK_BLOCKS, limit);
  endtask

  function automatic logic [BLOCK_BITS-1:0] rand_block(input logic [CFG_DATA_W-1:0] limit,
                                                       input logic [BLOCK_BITS-1:0] prev);
    case ($urandom_range(9))
      0: return '0;
      1: return TOP_BLOCK;
      2: return (limit == 0) ? '0 : BLOCK_BITS'(limit - 1);
      3: return prev;
      4: return prev + BLOCK_BITS'($urandom_range(4)) - BLOCK_BITS'(2);
      5: return BLOCK_BITS'($urandom());
      default: return (limit == 0) ? '0 : BLOCK_BITS'($urandom_range(32'(limit - 1)));
    endcase
  endfunction

  // enqueue share drifts so the table swings between empty and full
  task automatic run_mix(input int n_items, input logic [CFG_DATA_W-1:0] limit,
                         input int hold_at, input int pause_at);
    int n;
    int enq_pct;
    logic [BLOCK_BITS-1:0] blk;
    logic [BLOCK_BITS-1:0] last_blk;
    enq_pct = 60;
    last_blk = '0;
    for (n = 0; n < n_items; n++) begin
      if (n % 24 == 0) enq_pct = $urandom_range(85, 20);
      if (n == pause_at) drain();
      hold_trigger <= (n == hold_at);
      if ($urandom_range(99) < enq_pct) begin
        blk = rand_block(limit, last_blk);
        last_blk = blk;
        send_word(OP_ENQUEUE, blk, TAG_W'($urandom()));
      end else begin
        send_word(OP_DISPATCH, BLOCK_BITS'($urandom()), TAG_W'($urandom()));
      end
    end
  endtask

  // far ping-pong seeks drive the travel total into saturation
  task automatic run_far_seeks(input int n_pairs);
    int n;
    for (n = 0; n < n_pairs; n++) begin
      if (n % 2 == 1)
        send_word(OP_ENQUEUE, TOP_BLOCK - BLOCK_BITS'($urandom_range(255)), TAG_W'($urandom()));
      else
        send_word(OP_ENQUEUE, BLOCK_BITS'($urandom_range(255)), TAG_W'($urandom()));
      send_word(OP_DISPATCH, BLOCK_BITS'($urandom()), TAG_W'($urandom()));
    end
  endtask

  initial begin
    #(10_000_000);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset policy: C-SCAN over the full disk
    send_word(OP_DISPATCH, '0, '0);
    send_word(OP_ENQUEUE, TOP_BLOCK, 8'hFF);
    send_word(OP_ENQUEUE, 24'd0, 8'h00);
    send_word(OP_ENQUEUE, 24'd800, 8'hA5);
    send_word(OP_ENQUEUE, 24'd800, 8'h5A);
    send_word(OP_ENQUEUE, 24'd300, 8'h11);
    send_word(OP_DISPATCH, '0, '0);
    send_word(OP_DISPATCH, '0, '0);
    send_word(OP_DISPATCH, '0, '0);
    send_word(OP_DISPATCH, '0, '0);
    send_word(OP_DISPATCH, '0, '0);

    set_policy(MODE_SSTF, CFG_DATA_W'(1000));
    send_word(OP_ENQUEUE, 24'd1000, 8'h01);
    send_word(OP_ENQUEUE, 24'd999, 8'h22);
    send_word(OP_ENQUEUE, 24'd990, 8'h33);
    send_word(OP_ENQUEUE, 24'd10, 8'h44);
    send_word(OP_DISPATCH, '0, '0);

    set_policy(MODE_SSTF, CFG_DATA_W'(0));
    send_word(OP_ENQUEUE, 24'd0, 8'h55);

    set_policy(MODE_FCFS, CFG_DATA_W'(1));
    send_word(OP_ENQUEUE, 24'd0, 8'h66);
    send_word(OP_ENQUEUE, 24'd1, 8'h77);
    send_word(OP_DISPATCH, '0, '0);

    set_policy(MODE_SPARE, CFG_DATA_W'(1));
    send_word(OP_DISPATCH, '0, '0);
    send_word(OP_DISPATCH, '0, '0);
    send_word(OP_DISPATCH, '0, '0);

    set_policy(MODE_CSCAN, FULL_SPAN);
    run_mix(250, FULL_SPAN, -1, -1);
    set_policy(MODE_SSTF, CFG_DATA_W'(64));
    run_mix(300, CFG_DATA_W'(64), -1, -1);

    send_idle_pct = 87;
    recv_idle_pct = 7;
    set_policy(MODE_FCFS, FULL_SPAN);
    run_far_seeks(300);
    set_policy(MODE_SPARE, CFG_DATA_W'(1));
    run_mix(80, CFG_DATA_W'(1), -1, -1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_policy(MODE_CSCAN, CFG_DATA_W'(4096));
    run_mix(200, CFG_DATA_W'(4096), 50, 120);
    set_policy(MODE_SSTF, FULL_SPAN);
    run_mix(100, FULL_SPAN, -1, -1);

    drain();
    repeat (50) @(negedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
